// ===== rtl/aip_pkg.sv =====
// Shared types and constants for the ASCII integer parser.
// Defines the operation word passed from the front end to the accumulator.
// No dependencies.
package aip_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       clr;
    logic       acc;
    logic       fin;
    logic       neg;
    logic [3:0] digit;
    logic [5:0] base;
  } op_t;

endpackage

// ===== rtl/aip_front.sv =====
// Front end of the ASCII integer parser: sign, prefix and digit classification.
// Holds the radix register and parse phase, emits op_t words.
// Depends on aip_pkg.
module aip_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [5:0]      cfg_wdata,
  input  logic            take,
  input  logic [7:0]      ch,
  input  logic            start_req,
  output logic            op_push,
  output aip_pkg::op_t    op
);
  import aip_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_ZERO, PH_DIGITS} phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [5:0] BASE_8   = 6'd8;
  localparam logic [5:0] BASE_10  = 6'd10;
  localparam logic [5:0] BASE_16  = 6'd16;

  phase_t     phase_r, phase_nxt;
  logic [5:0] radix_r;
  logic [5:0] base_r, base_nxt;
  logic       neg_r, neg_nxt;
  logic       dv;
  logic [3:0] dval;
  logic [5:0] lead_base;

  always_comb begin
    dv   = 1'b1;
    dval = 4'd0;
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      dval = 4'(ch - CH_ZERO);
    end else if (ch inside {[CH_LA:CH_LF]}) begin
      dval = 4'(ch - CH_LA + 8'd10);
    end else if (ch inside {[CH_UA:CH_UF]}) begin
      dval = 4'(ch - CH_UA + 8'd10);
    end else begin
      dv = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    op        = '0;
    op.digit  = dval;
    lead_base = start_req ? radix_r : base_r;
    if (start_req) begin
      op.clr  = 1'b1;
      neg_nxt = (ch == CH_MINUS);
    end
    if (start_req && ch == CH_MINUS) begin
      base_nxt  = radix_r;
      phase_nxt = PH_LEAD;
    end else if (start_req || phase_r == PH_LEAD) begin
      if (lead_base == 6'd0 && ch == CH_ZERO) begin
        base_nxt  = lead_base;
        phase_nxt = PH_ZERO;
      end else begin
        if (lead_base == 6'd0 && ch inside {[CH_ONE:CH_NINE]}) begin
          base_nxt = BASE_10;
        end else begin
          base_nxt = lead_base;
        end
        op.acc    = dv;
        op.fin    = !dv;
        phase_nxt = dv ? PH_DIGITS : PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_ZERO: begin
          if (ch == CH_NUL) begin
            op.fin    = 1'b1;
            neg_nxt   = 1'b0;
            phase_nxt = PH_IDLE;
          end else if (ch == CH_LX || ch == CH_UX) begin
            base_nxt  = BASE_16;
            phase_nxt = PH_DIGITS;
          end else begin
            base_nxt  = BASE_8;
            op.acc    = dv;
            op.fin    = !dv;
            phase_nxt = dv ? PH_DIGITS : PH_IDLE;
          end
        end
        PH_DIGITS: begin
          op.acc    = dv;
          op.fin    = !dv;
          phase_nxt = dv ? PH_DIGITS : PH_IDLE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    op.base = base_nxt;
    op.neg  = neg_nxt;
    op_push = take && (op.clr || op.acc || op.fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      radix_r <= 6'd0;
      base_r  <= 6'd0;
      neg_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (take) begin
        phase_r <= phase_nxt;
        base_r  <= base_nxt;
        neg_r   <= neg_nxt;
      end
    end
  end

endmodule

// ===== rtl/aip_queue.sv =====
// Short queue of op_t words between the front end and the accumulator.
// Depth set by aip_pkg::QDEPTH.
// Depends on aip_pkg.
module aip_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  aip_pkg::op_t    wr_op,
  output logic            full,
  input  logic            rd_en,
  output aip_pkg::op_t    rd_op,
  output logic            empty
);
  import aip_pkg::*;

  op_t             mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QAW:0]    cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rd_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/aip_back.sv =====
// Accumulator back end of the ASCII integer parser.
// Executes op_t words: shift-or or multiply-add, negate and emit the result word.
// Depends on aip_pkg.
module aip_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  aip_pkg::op_t    op,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [63:0]     out_value
);
  import aip_pkg::*;

  localparam logic [5:0] BASE_8  = 6'd8;
  localparam logic [5:0] BASE_16 = 6'd16;

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] acc_base;
  logic [63:0] prod;
  logic [63:0] value_r;
  logic        valid_r;
  logic        slot_free;

  assign slot_free = !valid_r || pop;
  assign q_pop     = !q_empty && (!op.fin || slot_free);
  assign acc_base  = op.clr ? 64'd0 : acc_r;
  assign prod      = acc_base * 64'(op.base);

  always_comb begin
    acc_nxt = acc_base;
    if (op.acc) begin
      if (op.base == BASE_8) begin
        acc_nxt = {acc_base[60:0], 3'b000} | 64'(op.digit);
      end else if (op.base == BASE_16) begin
        acc_nxt = {acc_base[59:0], 4'b0000} | 64'(op.digit);
      end else begin
        acc_nxt = prod + 64'(op.digit);
      end
    end
  end

  assign empty     = !valid_r;
  assign out_value = value_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      acc_r <= acc_nxt;
    end
    if (q_pop && op.fin) begin
      value_r <= op.neg ? (64'd0 - acc_base) : acc_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop && op.fin) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/ascii_integer_parser_core.sv =====
// ASCII integer parser: one character word per cycle in while full is low, one 64-bit value word out.
// A result word passes through the op queue and the output value register before it appears on out_value.
// Throughput: one character per cycle while the op queue is not full, set by the accumulator update.
// A four-word op queue separates classification from accumulation.
// Reset (rst_n low, synchronous) clears the radix, parse phase, op queue and output slot.
module ascii_integer_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_ch,
  input  logic        in_start_req,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_value
);
  import aip_pkg::*;

  op_t  f_op;
  op_t  q_op;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic take;
  logic out_empty;

  assign take  = push && !q_full;
  assign full  = q_full;
  assign empty = out_empty;

  aip_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .ch        (in_ch),
    .start_req (in_start_req),
    .op_push   (f_push),
    .op        (f_op)
  );

  aip_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (f_push),
    .wr_op (f_op),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_op (q_op),
    .empty (q_empty)
  );

  aip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .op        (q_op),
    .q_pop     (q_pop),
    .pop       (pop && !out_empty),
    .empty     (out_empty),
    .out_value (out_value)
  );

endmodule
